>>> rtl/core/pfa_pkg.sv
// Shared types and constants of the page frame allocator.
package pfa_pkg;

    localparam int ADDR_W     = 32;
    localparam int CFG_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int SHIFT_W    = 5;
    localparam int STATUS_W   = 2;
    // A 32-bit address shifted right by at least 10 leaves 22 bits of page index.
    localparam int PIDX_W     = 22;

    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SHIFT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_PAGES = 2'd2;

    localparam logic [SHIFT_W-1:0] SHIFT_RST    = 5'd12;
    localparam logic [SHIFT_W-1:0] SHIFT_MIN    = 5'd10;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX    = 5'd16;
    localparam logic [CFG_W-1:0]   COUNT_RST    = 13'd4096;
    localparam logic [CFG_W-1:0]   RESERVED_RST = 13'd1;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DOUBLE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd3;

    typedef struct packed {
        logic              is_free;
        logic              out_of_range;
        logic [PIDX_W-1:0] page_idx;
    } req_t;

endpackage

>>> rtl/core/pfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pfa_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/pfa_queue.sv
// Two-word queue of classified requests between the front and back parts.
module pfa_queue
    import pfa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  req_t push_data,
    input  logic pop,
    output logic full,
    output logic not_empty,
    output req_t head_data
);

    req_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;

    assign full      = (fill_reg == 2'd2);
    assign not_empty = (fill_reg != 2'd0);
    assign head_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/core/pfa_front.sv
// Front part: takes requests, turns addresses into page indices and checks the range.
module pfa_front
    import pfa_pkg::*;
#(
    parameter int CNT_W = 13
) (
    input  logic               start,
    output logic               busy,
    input  logic               func,
    input  logic [ADDR_W-1:0]  page_address,
    input  logic [SHIFT_W-1:0] shift_eff,
    input  logic [CNT_W-1:0]   count_eff,
    input  logic               q_full,
    input  logic               clearing,
    output logic               push,
    output req_t               push_data
);

    logic [ADDR_W-1:0] shifted;

    assign busy    = q_full || clearing;
    assign push    = start && !busy;
    assign shifted = page_address >> shift_eff;

    always_comb
    begin
        push_data.is_free      = (func == FUNC_FREE);
        push_data.page_idx     = shifted[PIDX_W-1:0];
        push_data.out_of_range = (shifted[PIDX_W-1:0] >= PIDX_W'(count_eff));
    end

endmodule

>>> rtl/core/pfa_back.sv
// Back part: fresh page counter, freed ring, freed marks and the result register.
module pfa_back
    import pfa_pkg::*;
#(
    parameter int MAX_PAGES = 4096,
    parameter int IDX_W     = 12,
    parameter int CNT_W     = 13,
    parameter int FRESH_W   = 13
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  req_t                q_data,
    output logic                q_pop,
    input  logic [SHIFT_W-1:0]  shift_eff,
    input  logic [CNT_W-1:0]    count_eff,
    input  logic                reinit,
    input  logic [CFG_W-1:0]    reserved_init,
    output logic                clearing,
    output logic                done,
    output logic [ADDR_W-1:0]   granted_address,
    output logic [STATUS_W-1:0] status
);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_RING = 2'd1;
    localparam logic [1:0] B_MARK = 2'd2;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_PAGES - 1);

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    logic [FRESH_W-1:0] fresh_reg;
    logic [FRESH_W-1:0] fresh_next;
    logic [IDX_W-1:0]   head_reg;
    logic [IDX_W-1:0]   head_next;
    logic [IDX_W-1:0]   tail_reg;
    logic [IDX_W-1:0]   tail_next;
    logic [CNT_W-1:0]   rcount_reg;
    logic [CNT_W-1:0]   rcount_next;
    logic               clear_reg;
    logic               clear_next;
    logic [IDX_W-1:0]   clr_addr_reg;
    logic [IDX_W-1:0]   clr_addr_next;
    logic [IDX_W-1:0]   cur_idx_reg;
    logic [IDX_W-1:0]   cur_idx_next;
    logic               done_reg;
    logic               done_next;
    logic [ADDR_W-1:0]  granted_reg;
    logic [ADDR_W-1:0]  granted_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;

    logic               mark_we;
    logic [IDX_W-1:0]   mark_waddr;
    logic               mark_wdata;
    logic [IDX_W-1:0]   mark_raddr;
    logic               mark_rdata;
    logic               ring_we;
    logic [IDX_W-1:0]   ring_rdata;

    function automatic logic [IDX_W-1:0] ring_step(input logic [IDX_W-1:0] p);
        return (p == LAST_IDX) ? '0 : p + 1'b1;
    endfunction

    pfa_ram #(
        .WIDTH (1),
        .DEPTH (MAX_PAGES)
    ) u_mark_ram (
        .clk   (clk),
        .we    (mark_we),
        .waddr (mark_waddr),
        .wdata (mark_wdata),
        .raddr (mark_raddr),
        .rdata (mark_rdata)
    );

    pfa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_PAGES)
    ) u_ring_ram (
        .clk   (clk),
        .we    (ring_we),
        .waddr (tail_reg),
        .wdata (cur_idx_reg),
        .raddr (head_reg),
        .rdata (ring_rdata)
    );

    assign clearing        = clear_reg;
    assign done            = done_reg;
    assign granted_address = granted_reg;
    assign status          = status_reg;
    assign mark_raddr      = q_data.page_idx[IDX_W-1:0];

    always_comb
    begin
        state_next    = state_reg;
        fresh_next    = fresh_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        rcount_next   = rcount_reg;
        clear_next    = clear_reg;
        clr_addr_next = clr_addr_reg;
        cur_idx_next  = cur_idx_reg;
        done_next     = 1'b0;
        granted_next  = granted_reg;
        status_next   = status_reg;
        mark_we       = 1'b0;
        mark_waddr    = clr_addr_reg;
        mark_wdata    = 1'b0;
        ring_we       = 1'b0;
        q_pop         = 1'b0;

        if (reinit)
        begin
            state_next    = B_IDLE;
            fresh_next    = FRESH_W'(reserved_init);
            head_next     = '0;
            tail_next     = '0;
            rcount_next   = '0;
            clear_next    = 1'b1;
            clr_addr_next = '0;
        end
        else if (clear_reg)
        begin
            // One mark word is cleared per cycle until the whole store is swept.
            mark_we       = 1'b1;
            clr_addr_next = ring_step(clr_addr_reg);
            if (clr_addr_reg == LAST_IDX)
            begin
                clear_next = 1'b0;
            end
        end
        else
        begin
            case (state_reg)
                B_IDLE:
                begin
                    if (q_valid)
                    begin
                        q_pop        = 1'b1;
                        granted_next = '0;
                        status_next  = ST_OK;
                        cur_idx_next = q_data.page_idx[IDX_W-1:0];
                        if (!q_data.is_free)
                        begin
                            if (fresh_reg < FRESH_W'(count_eff))
                            begin
                                done_next    = 1'b1;
                                granted_next = ADDR_W'(fresh_reg) << shift_eff;
                                fresh_next   = fresh_reg + 1'b1;
                            end
                            else if (rcount_reg != '0)
                            begin
                                // The ring head word arrives next cycle.
                                head_next   = ring_step(head_reg);
                                rcount_next = rcount_reg - 1'b1;
                                state_next  = B_RING;
                            end
                            else
                            begin
                                done_next   = 1'b1;
                                status_next = ST_EMPTY;
                            end
                        end
                        else if (q_data.out_of_range)
                        begin
                            done_next   = 1'b1;
                            status_next = ST_RANGE;
                        end
                        else if (q_data.page_idx >= PIDX_W'(fresh_reg))
                        begin
                            done_next   = 1'b1;
                            status_next = ST_DOUBLE;
                        end
                        else
                        begin
                            state_next = B_MARK;
                        end
                    end
                end
                B_RING:
                begin
                    mark_we      = 1'b1;
                    mark_waddr   = ring_rdata;
                    mark_wdata   = 1'b0;
                    done_next    = 1'b1;
                    status_next  = ST_OK;
                    granted_next = ADDR_W'(ring_rdata) << shift_eff;
                    state_next   = B_IDLE;
                end
                B_MARK:
                begin
                    done_next    = 1'b1;
                    granted_next = '0;
                    if (mark_rdata)
                    begin
                        status_next = ST_DOUBLE;
                    end
                    else
                    begin
                        status_next = ST_OK;
                        mark_we     = 1'b1;
                        mark_waddr  = cur_idx_reg;
                        mark_wdata  = 1'b1;
                        ring_we     = 1'b1;
                        tail_next   = ring_step(tail_reg);
                        rcount_next = rcount_reg + 1'b1;
                    end
                    state_next = B_IDLE;
                end
                default:
                begin
                    state_next = B_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_IDLE;
            fresh_reg    <= FRESH_W'(RESERVED_RST);
            head_reg     <= '0;
            tail_reg     <= '0;
            rcount_reg   <= '0;
            clear_reg    <= 1'b1;
            clr_addr_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fresh_reg    <= fresh_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            rcount_reg   <= rcount_next;
            clear_reg    <= clear_next;
            clr_addr_reg <= clr_addr_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_idx_reg <= cur_idx_next;
        granted_reg <= granted_next;
        status_reg  <= status_next;
    end

endmodule

>>> rtl/core/fifo_page_frame_allocator_top.sv
// Top level of the page frame allocator with a first-in, first-out free queue.
//
//  Channel    Handshake          Words
//  ---------  -----------------  ---------------------------------------
//  request    start / busy       func, page_address
//  result     done (one cycle)   granted_address, status
//  config     cfg_we             cfg_index, cfg_wdata
//
// A request that needs no memory read is finished by the back part in B_IDLE; an
// allocate from the freed ring or a free of an issued page in range goes on to B_RING
// or B_MARK, set by the read then write-back of the ring and mark memories. The result
// appears in the cycle after the back part finishes with done high; it cannot be stalled.
// After reset and after each register write the mark memory is swept, one
// word a cycle, through all MAX_PAGES words with busy high.
module fifo_page_frame_allocator_top
    import pfa_pkg::*;
#(
    parameter int MAX_PAGES = 4096
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 func,
    input  logic [ADDR_W-1:0]    page_address,
    output logic                 done,
    output logic [ADDR_W-1:0]    granted_address,
    output logic [STATUS_W-1:0]  status,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    localparam int IDX_W   = $clog2(MAX_PAGES);
    localparam int CNT_W   = $clog2(MAX_PAGES + 1);
    localparam int FRESH_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    logic [SHIFT_W-1:0] page_shift_reg;
    logic [CFG_W-1:0]   page_count_reg;
    logic [CFG_W-1:0]   reserved_reg;
    logic [SHIFT_W-1:0] shift_eff;
    logic [CNT_W-1:0]   count_eff;
    logic [FRESH_W-1:0] count_wide;
    logic               reinit;
    logic [CFG_W-1:0]   reserved_init;

    logic               push;
    req_t               push_data;
    logic               q_full;
    logic               q_valid;
    req_t               q_data;
    logic               q_pop;
    logic               clearing;

    // Any write to a listed register starts the allocator afresh.
    assign reinit = cfg_we && ((cfg_index == CFG_PAGE_SHIFT) ||
                               (cfg_index == CFG_PAGE_COUNT) ||
                               (cfg_index == CFG_RESERVED_PAGES));
    assign reserved_init = (cfg_we && (cfg_index == CFG_RESERVED_PAGES)) ?
                           cfg_wdata : reserved_reg;

    always_comb
    begin
        if (page_shift_reg < SHIFT_MIN)
        begin
            shift_eff = SHIFT_MIN;
        end
        else if (page_shift_reg > SHIFT_MAX)
        begin
            shift_eff = SHIFT_MAX;
        end
        else
        begin
            shift_eff = page_shift_reg;
        end
        count_wide = FRESH_W'(page_count_reg);
        count_eff  = (count_wide < FRESH_W'(MAX_PAGES)) ? CNT_W'(count_wide) :
                     CNT_W'(MAX_PAGES);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_shift_reg <= SHIFT_RST;
            page_count_reg <= COUNT_RST;
            reserved_reg   <= RESERVED_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PAGE_SHIFT:     page_shift_reg <= cfg_wdata[SHIFT_W-1:0];
                CFG_PAGE_COUNT:     page_count_reg <= cfg_wdata;
                CFG_RESERVED_PAGES: reserved_reg   <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    pfa_front #(
        .CNT_W (CNT_W)
    ) u_front (
        .start        (start),
        .busy         (busy),
        .func         (func),
        .page_address (page_address),
        .shift_eff    (shift_eff),
        .count_eff    (count_eff),
        .q_full       (q_full),
        .clearing     (clearing),
        .push         (push),
        .push_data    (push_data)
    );

    pfa_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_valid),
        .head_data (q_data)
    );

    pfa_back #(
        .MAX_PAGES (MAX_PAGES),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W),
        .FRESH_W   (FRESH_W)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_data          (q_data),
        .q_pop           (q_pop),
        .shift_eff       (shift_eff),
        .count_eff       (count_eff),
        .reinit          (reinit),
        .reserved_init   (reserved_init),
        .clearing        (clearing),
        .done            (done),
        .granted_address (granted_address),
        .status          (status)
    );

endmodule

>>> tb/sv/pfa_grant_checker.sv
// Checker that predicts each allocator result and compares it with the block's output.
`timescale 1ns / 1ps
module pfa_grant_checker
    import pfa_pkg::*;
#(
    parameter int MAX_PAGES = 4096
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  logic                 func,
    input  logic [ADDR_W-1:0]    page_address,
    input  logic                 done,
    input  logic [ADDR_W-1:0]    granted_address,
    input  logic [STATUS_W-1:0]  status,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    output int unsigned          mismatches,
    output int unsigned          pending
);

    localparam int RING_W = $clog2(MAX_PAGES);

    typedef struct {
        logic [ADDR_W-1:0]   address;
        logic [STATUS_W-1:0] code;
    } grant_t;

    // Mirror of the registers.
    logic [SHIFT_W-1:0]   shift_cfg;
    logic [CFG_W-1:0]     count_cfg;
    logic [CFG_W-1:0]     reserved_cfg;

    // Mirror of the allocator state.
    logic [CFG_W-1:0]     fresh_next;
    logic [RING_W-1:0]    freed_ring [MAX_PAGES];
    logic [RING_W-1:0]    ring_head;
    logic [RING_W-1:0]    ring_tail;
    logic [RING_W:0]      ring_count;
    logic [MAX_PAGES-1:0] freed_mark;

    grant_t expected_grants[$];
    grant_t oldest;

    task automatic clear_allocator();
        fresh_next = reserved_cfg;
        freed_mark = '0;
        ring_head  = '0;
        ring_tail  = '0;
        ring_count = '0;
    endtask

    task automatic predict_grant(input logic req_func, input logic [ADDR_W-1:0] addr);
        int unsigned       shift;
        int unsigned       limit;
        logic [ADDR_W-1:0] pidx;
        grant_t            g;
        shift = 32'((shift_cfg < SHIFT_MIN) ? SHIFT_MIN :
                    (shift_cfg > SHIFT_MAX) ? SHIFT_MAX : shift_cfg);
        limit = (32'(count_cfg) < MAX_PAGES) ? 32'(count_cfg) : MAX_PAGES;
        g.address = '0;
        g.code    = ST_OK;
        if (req_func == FUNC_ALLOC)
        begin
            // Never-issued pages go first, in ascending order, then the freed ones.
            if (fresh_next < limit)
            begin
                pidx       = ADDR_W'(fresh_next);
                fresh_next = fresh_next + 1'b1;
                g.address  = pidx << shift;
            end
            else if (ring_count != 0)
            begin
                pidx                         = ADDR_W'(freed_ring[ring_head]);
                freed_mark[pidx[RING_W-1:0]] = 1'b0;
                ring_head  = (ring_head == RING_W'(MAX_PAGES - 1)) ? '0 :
                             ring_head + 1'b1;
                ring_count = ring_count - 1'b1;
                g.address  = pidx << shift;
            end
            else
            begin
                g.code = ST_EMPTY;
            end
        end
        else
        begin
            pidx = addr >> shift;
            if (pidx >= limit)
            begin
                g.code = ST_RANGE;
            end
            else if (pidx >= fresh_next || freed_mark[pidx[RING_W-1:0]])
            begin
                g.code = ST_DOUBLE;
            end
            else
            begin
                freed_mark[pidx[RING_W-1:0]] = 1'b1;
                freed_ring[ring_tail]        = pidx[RING_W-1:0];
                ring_tail  = (ring_tail == RING_W'(MAX_PAGES - 1)) ? '0 :
                             ring_tail + 1'b1;
                ring_count = ring_count + 1'b1;
            end
        end
        expected_grants.push_back(g);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_cfg    = SHIFT_RST;
            count_cfg    = COUNT_RST;
            reserved_cfg = RESERVED_RST;
            clear_allocator();
            expected_grants.delete();
            mismatches = 0;
            pending    = 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_grants.size() == 0)
                begin
                    $error("result word with no request outstanding: granted_address %h, status %0d",
                           granted_address, status);
                    mismatches++;
                end
                else
                begin
                    oldest = expected_grants.pop_front();
                    if (granted_address !== oldest.address)
                    begin
                        $error("granted_address mismatch: expected %h, actual %h",
                               oldest.address, granted_address);
                        mismatches++;
                    end
                    if (status !== oldest.code)
                    begin
                        $error("status mismatch: expected %0d, actual %0d", oldest.code, status);
                        mismatches++;
                    end
                end
            end
            // Each write to a real register starts the allocator afresh.
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PAGE_SHIFT:
                    begin
                        shift_cfg = cfg_wdata[SHIFT_W-1:0];
                        clear_allocator();
                    end
                    CFG_PAGE_COUNT:
                    begin
                        count_cfg = cfg_wdata;
                        clear_allocator();
                    end
                    CFG_RESERVED_PAGES:
                    begin
                        reserved_cfg = cfg_wdata;
                        clear_allocator();
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (start && !busy)
                predict_grant(func, page_address);
            pending = expected_grants.size();
        end
    end

endmodule

>>> tb/sv/testbench.sv
// Top of the allocator testbench: clock, reset, request and register stimulus, and verdict.
`timescale 1ns / 1ps
module testbench;
    import pfa_pkg::*;

    localparam int MAX_PAGES = 4096;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 90;
    localparam int NO_IDLE_PHASE = 5;
    localparam int UNUSED_WRITE_PHASE = 6;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic                 func;
    logic [ADDR_W-1:0]    page_address;
    logic                 done;
    logic [ADDR_W-1:0]    granted_address;
    logic [STATUS_W-1:0]  status;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    int unsigned          mismatches;
    int unsigned          pending;

    // What the requester knows: pages it now holds and addresses it freed lately.
    logic [ADDR_W-1:0] held_pages[$];
    logic [ADDR_W-1:0] recent_frees[$];
    logic              issued_funcs[$];
    int unsigned       page_bits;
    int unsigned       page_limit;
    int unsigned       idle_pct;

    // Register settings of the phases that follow the run at reset values.
    int unsigned phase_shift [PHASES] = '{10, 16, 0, 31, 17, 13, 11, 14};
    int unsigned phase_count [PHASES] = '{1, 8, 16, 0, 8191, 4096, 37, 4095};
    int unsigned phase_resv  [PHASES] = '{0, 3, 16, 0, 8191, 0, 5, 4096};

    fifo_page_frame_allocator_top #(
        .MAX_PAGES (MAX_PAGES)
    ) i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .func            (func),
        .page_address    (page_address),
        .done            (done),
        .granted_address (granted_address),
        .status          (status),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata)
    );

    pfa_grant_checker #(
        .MAX_PAGES (MAX_PAGES)
    ) i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .func            (func),
        .page_address    (page_address),
        .done            (done),
        .granted_address (granted_address),
        .status          (status),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .mismatches      (mismatches),
        .pending         (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Pages that were granted become candidates for later frees.
    always @(posedge clk)
    begin
        if (done && issued_funcs.size() != 0)
        begin
            if (issued_funcs.pop_front() == FUNC_ALLOC && status == ST_OK)
                held_pages.push_back(granted_address);
        end
    end

    task automatic send_request(input logic req_func, input logic [ADDR_W-1:0] addr);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start        <= 1'b1;
        func         <= req_func;
        page_address <= addr;
        do
            @(posedge clk);
        while (busy);
        issued_funcs.push_back(req_func);
        @(negedge clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        // Let the back end settle before any register changes.
        repeat (4)
            @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        // The mark memory is swept after a write to a listed register; wait until it is done.
        while (busy)
            @(negedge clk);
    endtask

    task automatic issue_random_request();
        int unsigned       pick;
        int unsigned       slot;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] offset;
        pick   = $urandom_range(0, 99);
        offset = $urandom & ((32'd1 << page_bits) - 1);
        if (pick < 48)
        begin
            send_request(FUNC_ALLOC, $urandom);
        end
        else if (pick < 80 && held_pages.size() != 0)
        begin
            slot = $urandom_range(0, held_pages.size() - 1);
            addr = held_pages[slot] | offset;
            held_pages.delete(slot);
            recent_frees.push_back(addr);
            if (recent_frees.size() > 16)
                recent_frees.delete(0);
            send_request(FUNC_FREE, addr);
        end
        else if (pick < 88 && recent_frees.size() != 0)
        begin
            // Most of these hit a page that is still free, a few one that came back.
            slot = $urandom_range(0, recent_frees.size() - 1);
            send_request(FUNC_FREE, recent_frees[slot] ^ offset);
        end
        else if (pick < 94)
        begin
            addr = $urandom_range(page_limit, 32'hFFFF_FFFF >> page_bits);
            send_request(FUNC_FREE, (addr << page_bits) | offset);
        end
        else
        begin
            send_request(FUNC_FREE, $urandom);
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        func         = FUNC_ALLOC;
        page_address = '0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_PAGE_SHIFT;
        cfg_wdata    = '0;
        idle_pct     = 32;
        page_bits    = 32'(SHIFT_RST);
        page_limit   = 32'(COUNT_RST);
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset values: 4 KiB pages, 4096 of them, page 0 reserved.
        send_request(FUNC_ALLOC, 32'hFFFF_FFFF);
        send_request(FUNC_ALLOC, 32'h0000_0000);
        send_request(FUNC_FREE, 32'h0000_1000);
        send_request(FUNC_FREE, 32'h0000_1ABC);
        // A reserved page counts as in use, so it may be freed once.
        send_request(FUNC_FREE, 32'h0000_0000);
        send_request(FUNC_FREE, 32'h0000_0FFF);
        send_request(FUNC_FREE, 32'h00FF_F000);
        send_request(FUNC_FREE, 32'h0100_0000);
        send_request(FUNC_FREE, 32'hFFFF_FFFF);
        send_request(FUNC_FREE, 32'h0000_2FFF);
        send_request(FUNC_ALLOC, 32'h5555_5555);
        drain_results();
        held_pages.delete();
        recent_frees.delete();
        repeat (80)
            issue_random_request();

        for (int p = 0; p < PHASES; p++)
        begin
            drain_results();
            write_register(CFG_PAGE_SHIFT, CFG_W'(phase_shift[p]));
            write_register(CFG_PAGE_COUNT, CFG_W'(phase_count[p]));
            write_register(CFG_RESERVED_PAGES, CFG_W'(phase_resv[p]));
            page_bits  = (phase_shift[p] < 32'(SHIFT_MIN)) ? 32'(SHIFT_MIN) :
                         (phase_shift[p] > 32'(SHIFT_MAX)) ? 32'(SHIFT_MAX) : phase_shift[p];
            page_limit = (phase_count[p] < MAX_PAGES) ? phase_count[p] : MAX_PAGES;
            held_pages.delete();
            recent_frees.delete();
            idle_pct = (p == NO_IDLE_PHASE) ? 0 : 32;
            repeat (PHASE_ITEMS)
                issue_random_request();
            if (p == UNUSED_WRITE_PHASE)
            begin
                // A write to the spare index must leave the allocator as it is.
                drain_results();
                write_register(CFG_UNUSED, CFG_W'($urandom));
                repeat (20)
                    issue_random_request();
            end
        end

        drain_results();
        repeat (16)
            @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
